// ===== rtl/gcode_motion_state_step_macros.svh =====
// Assertion macros used by the motion step controller.
`ifndef GCODE_MOTION_STATE_STEP_MACROS_SVH
`define GCODE_MOTION_STATE_STEP_MACROS_SVH
`ifndef SYNTHESIS
// The consequent holds in the same cycle as the antecedent.
`define GMSS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// The consequent holds in the cycle after the antecedent.
`define GMSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define GMSS_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define GMSS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/gmss_pkg.sv =====
// Types and constants of the G-code motion step block.
package gmss_pkg;

   // Command kinds.
   typedef enum logic [3:0] {
      KIND_RAPID   = 4'd0,
      KIND_FEED    = 4'd1,
      KIND_DWELL   = 4'd2,
      KIND_ABS     = 4'd3,
      KIND_REL     = 4'd4,
      KIND_END     = 4'd5,
      KIND_SPIN_CW = 4'd6,
      KIND_SPIN_CCW = 4'd7,
      KIND_SPIN_OFF = 4'd8
   } kind_type;

   // Result error codes.
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MISSING   = 2'd1,
      ERR_TOO_MANY  = 2'd2,
      ERR_ZERO_MOVE = 2'd3
   } err_type;

   // Spindle modes.
   localparam logic [1:0] SPIN_STOP = 2'd0;
   localparam logic [1:0] SPIN_CW   = 2'd1;
   localparam logic [1:0] SPIN_CCW  = 2'd2;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_START_X    = 3'd0,
      REG_START_Y    = 3'd1,
      REG_START_Z    = 3'd2,
      REG_START_REL  = 3'd3,
      REG_XY_RAPID   = 3'd4,
      REG_XY_FEED    = 3'd5,
      REG_Z_RAPID    = 3'd6,
      REG_Z_FEED     = 3'd7
   } reg_type;

   // CORDIC datapath width, normalization bit and gain in Q30.
   localparam int CORDIC_W = 54;
   localparam int NORM_BIT = 48;
   localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_NORM,
      S_VEC,
      S_ROT,
      S_FIN
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic norm_en;
      logic vec_en;
      logic rot_en;
      logic cnt_clr;
      logic speed_wr;
      logic load_out;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_split;
      logic norm_done;
      logic mag_zero;
      logic step_last;
   } status_type;

endpackage

// ===== rtl/gcode_motion_state_step.sv =====
// Motion state step of a small G-code interpreter: top level.
// Takes one parsed command a beat and returns one result beat with the
// positions, velocity, spindle mode and flags after it. Mode, spindle,
// dwell, end and rejected or Z/A moves load the result as they are
// accepted. An XY move runs the direction CORDIC: it doubles the delta
// until it is normalized (more doublings for tiny moves), then runs
// CORDIC_STEPS vectoring and CORDIC_STEPS rotation iterations and a
// finish state that waits for the result register. One command is in
// flight at a time; a new one is taken when the result register is free
// or being emptied.
module gcode_motion_state_step #(
   parameter int COORD_WIDTH  = 32,
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tuser: kind[3:0]
   input  logic [3:0]   req_tuser,
   // tdata: has_x, has_y, has_z, has_a, has_p, x_value[31:0], y_value,
   // z_value, a_value, zero fill
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: pos_x, pos_y, pos_z, pos_a, vel_x, vel_y (32 each), vel_z (31),
   // spindle (2), moving, paused, program_end, error (2), zero fill
   output logic [231:0] rsp_tdata
);

   gmss_pkg::cmd_type    cmd;
   gmss_pkg::status_type status;

   gmss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gmss_dp #(
      .COORD_WIDTH  (COORD_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/gmss_ctrl.sv =====
// Sequencer of the motion step block: handshakes and CORDIC phases.
`include "gcode_motion_state_step_macros.svh"
module gmss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  gmss_pkg::status_type status,
   output gmss_pkg::cmd_type    cmd
);

   gmss_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;

   // The result register is free when empty or emptied in this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == gmss_pkg::S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gmss_pkg::S_IDLE: begin
            if (accept && status.need_split) state_in = gmss_pkg::S_NORM;
         end
         gmss_pkg::S_NORM: begin
            if (status.mag_zero) state_in = gmss_pkg::S_FIN;
            else if (status.norm_done) state_in = gmss_pkg::S_VEC;
         end
         gmss_pkg::S_VEC: begin
            if (status.step_last) state_in = gmss_pkg::S_ROT;
         end
         gmss_pkg::S_ROT: begin
            if (status.step_last) state_in = gmss_pkg::S_FIN;
         end
         gmss_pkg::S_FIN: begin
            if (out_free) state_in = gmss_pkg::S_IDLE;
         end
         default: state_in = gmss_pkg::S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         gmss_pkg::S_IDLE: begin
            cmd.accept   = accept;
            cmd.cnt_clr  = accept;
            cmd.load_out = accept && !status.need_split;
         end
         gmss_pkg::S_NORM: begin
            cmd.norm_en = !status.mag_zero && !status.norm_done;
         end
         gmss_pkg::S_VEC: begin
            cmd.vec_en  = 1'b1;
            cmd.cnt_clr = status.step_last;
         end
         gmss_pkg::S_ROT: begin
            cmd.rot_en = 1'b1;
         end
         gmss_pkg::S_FIN: begin
            cmd.speed_wr = out_free;
            cmd.load_out = out_free;
         end
         default: cmd = '0;
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gmss_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `GMSS_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_out, rsp_valid_ff)
   `GMSS_ASSERT_SAME(a_busy_not_ready, clock, reset, state_ff != gmss_pkg::S_IDLE, !req_tready)
   `GMSS_ASSERT_NEXT(a_vec_to_rot, clock, reset,
      (state_ff == gmss_pkg::S_VEC) && status.step_last, state_ff == gmss_pkg::S_ROT)
   `GMSS_ASSERT_SAME(a_fin_writes_speed, clock, reset, cmd.speed_wr,
      cmd.load_out && (state_ff == gmss_pkg::S_FIN))

endmodule

// ===== rtl/gmss_dp.sv =====
// Datapath of the motion step block: state, move decode and CORDIC.
module gmss_dp #(
   parameter int COORD_WIDTH  = 32,
   parameter int CORDIC_STEPS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gmss_pkg::cmd_type    cmd,
   output gmss_pkg::status_type status,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic [3:0]           req_tuser,
   input  logic [135:0]         req_tdata,
   output logic [231:0]         rsp_tdata
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = gmss_pkg::CORDIC_W;
   localparam int CW = $clog2(CORDIC_STEPS);

   // Request fields.
   logic hx, hy, hz, ha, hp;
   logic signed [31:0] vx, vy, vz, va;
   assign hx = req_tdata[0];
   assign hy = req_tdata[1];
   assign hz = req_tdata[2];
   assign ha = req_tdata[3];
   assign hp = req_tdata[4];
   assign vx = $signed(req_tdata[36:5]);
   assign vy = $signed(req_tdata[68:37]);
   assign vz = $signed(req_tdata[100:69]);
   assign va = $signed(req_tdata[132:101]);

   // Architectural state and configuration.
   logic signed [W-1:0] pos_x_ff, pos_y_ff, pos_z_ff, pos_a_ff;
   logic signed [W-1:0] pos_x_in, pos_y_in, pos_z_in, pos_a_in;
   logic signed [31:0]  spd_x_ff, spd_y_ff, spd_x_in, spd_y_in;
   logic [30:0]         spd_z_ff, spd_z_in;
   logic [1:0]          spin_ff, spin_in;
   logic                rel_ff, rel_in, ended_ff, ended_in;
   logic [30:0]         xy_rapid_ff, xy_feed_ff, z_rapid_ff, z_feed_ff;
   logic                moving_ff, moving_in, paused_ff, paused_in;
   logic [1:0]          err_ff, err_in;

   // Next positions of a move.
   logic signed [W-1:0] nx_x, nx_y, nx_z, nx_a;
   assign nx_x = !hx ? pos_x_ff : rel_ff ? pos_x_ff + W'(vx) : W'(vx);
   assign nx_y = !hy ? pos_y_ff : rel_ff ? pos_y_ff + W'(vy) : W'(vy);
   assign nx_z = !hz ? pos_z_ff : rel_ff ? pos_z_ff + W'(vz) : W'(vz);
   assign nx_a = !ha ? pos_a_ff : rel_ff ? pos_a_ff + W'(va) : W'(va);

   // Move decode and error priority.
   logic is_move, is_rapid, changed, move_ok;
   logic [1:0] move_err;
   assign is_move  = (req_tuser == gmss_pkg::KIND_RAPID) || (req_tuser == gmss_pkg::KIND_FEED);
   assign is_rapid = (req_tuser == gmss_pkg::KIND_RAPID);
   assign changed  = (nx_x != pos_x_ff) || (nx_y != pos_y_ff) ||
                     (nx_z != pos_z_ff) || (nx_a != pos_a_ff);
   always_comb begin
      if (!(hx || hy || hz || ha)) move_err = gmss_pkg::ERR_MISSING;
      else if (hx && hy && (hz || ha)) move_err = gmss_pkg::ERR_TOO_MANY;
      else if (!changed) move_err = gmss_pkg::ERR_ZERO_MOVE;
      else move_err = gmss_pkg::ERR_NONE;
   end
   assign move_ok = is_move && (move_err == gmss_pkg::ERR_NONE);
   assign status.need_split = move_ok && !hz && !ha;

   // XY delta, folded into the right half plane.
   logic signed [DW-1:0] dx, dy;
   logic flip;
   assign dx   = DW'(nx_x) - DW'(pos_x_ff);
   assign dy   = DW'(nx_y) - DW'(pos_y_ff);
   assign flip = dx[DW-1];

   // Speed scaled by the CORDIC gain.
   logic [30:0] xy_speed;
   logic [60:0] prod;
   assign xy_speed = is_rapid ? xy_rapid_ff : xy_feed_ff;
   assign prod     = 61'(xy_speed) * 61'(gmss_pkg::CORDIC_GAIN);

   // CORDIC registers.
   logic signed [DW-1:0] x_ff, y_ff, x_in, y_in, rx_ff, ry_ff, rx_in, ry_in;
   logic [CORDIC_STEPS-1:0] dirs_ff, dirs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic flip_ff, flip_in;

   // Normalization checks.
   logic signed [DW-1:0] y_abs, mag;
   assign y_abs = y_ff[DW-1] ? -y_ff : y_ff;
   assign mag   = (x_ff > y_abs) ? x_ff : y_abs;
   assign status.norm_done = |mag[DW-1:gmss_pkg::NORM_BIT];
   assign status.mag_zero  = (x_ff == '0) && (y_ff == '0);
   assign status.step_last = (cnt_ff == CW'(CORDIC_STEPS - 1));

   // One CORDIC iteration in each phase.
   logic signed [DW-1:0] sx, sy, srx, sry;
   assign sx  = x_ff >>> cnt_ff;
   assign sy  = y_ff >>> cnt_ff;
   assign srx = rx_ff >>> cnt_ff;
   assign sry = ry_ff >>> cnt_ff;

   always_comb begin
      x_in = x_ff; y_in = y_ff; rx_in = rx_ff; ry_in = ry_ff;
      dirs_in = dirs_ff; flip_in = flip_ff; cnt_in = cnt_ff;
      if (cmd.accept) begin
         x_in    = flip ? -dx : dx;
         y_in    = flip ? -dy : dy;
         flip_in = flip;
         rx_in   = DW'(prod[60:14]);
         ry_in   = '0;
      end
      if (cmd.norm_en) begin
         x_in = x_ff <<< 1;
         y_in = y_ff <<< 1;
      end
      if (cmd.vec_en) begin
         if (!y_ff[DW-1]) begin
            x_in = x_ff + sy;
            y_in = y_ff - sx;
            dirs_in[cnt_ff] = 1'b1;
         end else begin
            x_in = x_ff - sy;
            y_in = y_ff + sx;
            dirs_in[cnt_ff] = 1'b0;
         end
      end
      if (cmd.rot_en) begin
         if (dirs_ff[cnt_ff]) begin
            rx_in = rx_ff - sry;
            ry_in = ry_ff + srx;
         end else begin
            rx_in = rx_ff + sry;
            ry_in = ry_ff - srx;
         end
      end
      if (cmd.cnt_clr) cnt_in = '0;
      else if (cmd.vec_en || cmd.rot_en) cnt_in = cnt_ff + CW'(1);
   end

   // Round to Q16.16, undo the fold and saturate.
   function automatic logic signed [31:0] finish(input logic signed [DW-1:0] v,
                                                 input logic neg);
      logic signed [DW-1:0] q;
      logic signed [DW-1:0] r;
      q = (v + DW'(32768)) >>> 16;
      r = neg ? -q : q;
      if ((r[DW-1:31] != '0) && (r[DW-1:31] != '1))
         finish = r[DW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
      else
         finish = r[31:0];
   endfunction

   // State updates.
   always_comb begin
      pos_x_in = pos_x_ff; pos_y_in = pos_y_ff; pos_z_in = pos_z_ff; pos_a_in = pos_a_ff;
      spd_x_in = spd_x_ff; spd_y_in = spd_y_ff; spd_z_in = spd_z_ff;
      spin_in = spin_ff; rel_in = rel_ff; ended_in = ended_ff;
      moving_in = moving_ff; paused_in = paused_ff; err_in = err_ff;
      if (csr_we) begin
         unique case (gmss_pkg::reg_type'(csr_index))
            gmss_pkg::REG_START_X:   pos_x_in = W'($signed(csr_wdata));
            gmss_pkg::REG_START_Y:   pos_y_in = W'($signed(csr_wdata));
            gmss_pkg::REG_START_Z:   pos_z_in = W'($signed(csr_wdata));
            gmss_pkg::REG_START_REL: rel_in = csr_wdata[0];
            default: ;
         endcase
      end
      if (cmd.accept) begin
         moving_in = move_ok;
         paused_in = 1'b0;
         err_in    = gmss_pkg::ERR_NONE;
         unique case (req_tuser) inside
            gmss_pkg::KIND_RAPID, gmss_pkg::KIND_FEED: begin
               err_in = move_err;
               if (move_ok) begin
                  pos_x_in = nx_x; pos_y_in = nx_y; pos_z_in = nx_z; pos_a_in = nx_a;
                  if (hz) begin
                     spd_x_in = '0;
                     spd_y_in = '0;
                     spd_z_in = is_rapid ? z_rapid_ff : z_feed_ff;
                  end else if (!ha) begin
                     spd_z_in = '0;
                  end
               end
            end
            gmss_pkg::KIND_DWELL: begin
               paused_in = hp;
               err_in    = hp ? gmss_pkg::ERR_NONE : gmss_pkg::ERR_MISSING;
            end
            gmss_pkg::KIND_ABS:      rel_in = 1'b0;
            gmss_pkg::KIND_REL:      rel_in = 1'b1;
            gmss_pkg::KIND_END:      ended_in = 1'b1;
            gmss_pkg::KIND_SPIN_CW:  spin_in = gmss_pkg::SPIN_CW;
            gmss_pkg::KIND_SPIN_CCW: spin_in = gmss_pkg::SPIN_CCW;
            gmss_pkg::KIND_SPIN_OFF: spin_in = gmss_pkg::SPIN_STOP;
            default: ;
         endcase
      end
      if (cmd.speed_wr) begin
         spd_x_in = status.mag_zero ? 32'sd0 : finish(rx_ff, flip_ff);
         spd_y_in = status.mag_zero ? 32'sd0 : finish(ry_ff, flip_ff);
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0; pos_y_ff <= '0; pos_z_ff <= '0; pos_a_ff <= '0;
         spd_x_ff <= '0; spd_y_ff <= '0; spd_z_ff <= '0;
         spin_ff <= gmss_pkg::SPIN_STOP; rel_ff <= 1'b0; ended_ff <= 1'b0;
         xy_rapid_ff <= '0; xy_feed_ff <= '0; z_rapid_ff <= '0; z_feed_ff <= '0;
         cnt_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in; pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in; pos_a_ff <= pos_a_in;
         spd_x_ff <= spd_x_in; spd_y_ff <= spd_y_in; spd_z_ff <= spd_z_in;
         spin_ff <= spin_in; rel_ff <= rel_in; ended_ff <= ended_in;
         cnt_ff <= cnt_in;
         if (csr_we) begin
            unique case (gmss_pkg::reg_type'(csr_index))
               gmss_pkg::REG_XY_RAPID: xy_rapid_ff <= csr_wdata[30:0];
               gmss_pkg::REG_XY_FEED:  xy_feed_ff  <= csr_wdata[30:0];
               gmss_pkg::REG_Z_RAPID:  z_rapid_ff  <= csr_wdata[30:0];
               gmss_pkg::REG_Z_FEED:   z_feed_ff   <= csr_wdata[30:0];
               default: ;
            endcase
         end
      end
   end

   // Working registers and result beat.
   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; rx_ff <= rx_in; ry_ff <= ry_in;
      dirs_ff <= dirs_in; flip_ff <= flip_in;
      moving_ff <= moving_in; paused_ff <= paused_in; err_ff <= err_in;
      if (cmd.load_out) begin
         rsp_tdata <= {2'b00, err_in, ended_in, paused_in, moving_in, spin_in, spd_z_in,
                       spd_y_in, spd_x_in, 32'(pos_a_in), 32'(pos_z_in),
                       32'(pos_y_in), 32'(pos_x_in)};
      end
   end

endmodule

// ===== verif/gcode_motion_state_step_tb.sv =====
// Self-checking testbench for the G-code motion state step block.
`timescale 1ns / 1ps
module gcode_motion_state_step_tb;

   // Result beat as it sits in rsp_tdata, highest bits first.
   typedef struct packed {
      logic [1:0]  fill;
      logic [1:0]  err;
      logic        prog_end;
      logic        paused;
      logic        moving;
      logic [1:0]  spin;
      logic [30:0] vz;
      logic [31:0] vy;
      logic [31:0] vx;
      logic [31:0] pa;
      logic [31:0] pz;
      logic [31:0] py;
      logic [31:0] px;
   } motion_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [3:0]   req_tuser = '0;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [231:0] rsp_tdata;

   gcode_motion_state_step u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   // Mirror of the block's state and configuration.
   logic [31:0] tool_pos [4];
   longint      vel_x_q, vel_y_q;
   logic [30:0] vel_z_q;
   logic [1:0]  spin_q;
   logic        rel_q, end_q;
   logic [30:0] xy_rapid, xy_feed, z_rapid, z_feed;

   motion_result_type pending_results[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // CORDIC direction split of the XY path speed.
   function automatic void split_xy_speed(input longint dx, input longint dy,
                                          input logic [30:0] spd,
                                          output longint vx, output longint vy);
      bit flip;
      longint ady, mag, x, y, nx, ny, rx, ry, qx, qy;
      longint sat_hi, sat_lo;
      logic [63:0] dirs;
      longint unsigned prod;
      sat_hi = 64'sd2147483647;
      sat_lo = -64'sd2147483648;
      flip = dx < 0;
      if (flip) begin
         dx = -dx;
         dy = -dy;
      end
      ady = (dy < 0) ? -dy : dy;
      mag = (dx > ady) ? dx : ady;
      if (mag == 0) begin
         vx = 0;
         vy = 0;
         return;
      end
      while (mag < (64'sd1 <<< 48)) begin
         dx = dx * 2;
         dy = dy * 2;
         mag = mag * 2;
      end
      dirs = '0;
      x = dx;
      y = dy;
      for (int i = 0; i < 24; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            dirs[i] = 1'b1;
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
         end
         x = nx;
         y = ny;
      end
      prod = 64'(spd) * 64'(gmss_pkg::CORDIC_GAIN);
      rx = longint'(prod >> 14);
      ry = 0;
      for (int i = 0; i < 24; i++) begin
         if (dirs[i]) begin
            nx = rx - (ry >>> i);
            ny = ry + (rx >>> i);
         end else begin
            nx = rx + (ry >>> i);
            ny = ry - (rx >>> i);
         end
         rx = nx;
         ry = ny;
      end
      qx = (rx + 32768) >>> 16;
      qy = (ry + 32768) >>> 16;
      if (flip) begin
         qx = -qx;
         qy = -qy;
      end
      vx = (qx > sat_hi) ? sat_hi : (qx < sat_lo) ? sat_lo : qx;
      vy = (qy > sat_hi) ? sat_hi : (qy < sat_lo) ? sat_lo : qy;
   endfunction

   // Apply one command to the mirrored state and queue the result it yields.
   task automatic predict_command(input logic [3:0] kind, input logic [4:0] has,
                                  input logic [31:0] vals [4]);
      motion_result_type r;
      logic [31:0] nxt [4];
      logic [1:0] err;
      logic moving, paused;
      bit same;
      err = gmss_pkg::ERR_NONE;
      moving = 0;
      paused = 0;
      case (kind) inside
         gmss_pkg::KIND_RAPID, gmss_pkg::KIND_FEED: begin
            if (has[3:0] == 4'b0000) begin
               err = gmss_pkg::ERR_MISSING;
            end else if (has[0] && has[1] && (has[2] || has[3])) begin
               err = gmss_pkg::ERR_TOO_MANY;
            end else begin
               same = 1;
               for (int k = 0; k < 4; k++) begin
                  nxt[k] = tool_pos[k];
                  if (has[k]) nxt[k] = rel_q ? tool_pos[k] + vals[k] : vals[k];
                  if (nxt[k] != tool_pos[k]) same = 0;
               end
               if (same) begin
                  err = gmss_pkg::ERR_ZERO_MOVE;
               end else begin
                  if (has[2]) begin
                     vel_x_q = 0;
                     vel_y_q = 0;
                     vel_z_q = (kind == gmss_pkg::KIND_RAPID) ? z_rapid : z_feed;
                  end else if (!has[3]) begin
                     split_xy_speed(longint'($signed(nxt[0])) - longint'($signed(tool_pos[0])),
                                    longint'($signed(nxt[1])) - longint'($signed(tool_pos[1])),
                                    (kind == gmss_pkg::KIND_RAPID) ? xy_rapid : xy_feed,
                                    vel_x_q, vel_y_q);
                     vel_z_q = 0;
                  end
                  for (int k = 0; k < 4; k++) tool_pos[k] = nxt[k];
                  moving = 1;
               end
            end
         end
         gmss_pkg::KIND_DWELL: begin
            if (has[4]) paused = 1;
            else err = gmss_pkg::ERR_MISSING;
         end
         gmss_pkg::KIND_ABS: rel_q = 0;
         gmss_pkg::KIND_REL: rel_q = 1;
         gmss_pkg::KIND_END: end_q = 1;
         gmss_pkg::KIND_SPIN_CW: spin_q = gmss_pkg::SPIN_CW;
         gmss_pkg::KIND_SPIN_CCW: spin_q = gmss_pkg::SPIN_CCW;
         gmss_pkg::KIND_SPIN_OFF: spin_q = gmss_pkg::SPIN_STOP;
         default: ;
      endcase
      r.fill = '0;
      r.err = err;
      r.prog_end = end_q;
      r.paused = paused;
      r.moving = moving;
      r.spin = spin_q;
      r.vz = vel_z_q;
      r.vy = vel_y_q[31:0];
      r.vx = vel_x_q[31:0];
      r.pa = tool_pos[3];
      r.pz = tool_pos[2];
      r.py = tool_pos[1];
      r.px = tool_pos[0];
      pending_results.insert(pending_results.size(), r);
   endtask

   // Send one command beat; called and returning at a falling edge.
   task automatic send_command(input logic [3:0] kind, input logic [4:0] has,
                               input logic [31:0] xv, input logic [31:0] yv,
                               input logic [31:0] zv, input logic [31:0] av);
      logic [31:0] vals [4];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      vals[0] = xv;
      vals[1] = yv;
      vals[2] = zv;
      vals[3] = av;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {3'b000, av, zv, yv, xv, has};
      do @(posedge clock); while (!req_tready);
      predict_command(kind, has, vals);
      @(negedge clock);
   endtask

   // Wait until every queued result has arrived, with the sender quiet.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write; only issued while the block is idle. The caller drops
   // the write enable after its last write.
   task automatic write_reg(input gmss_pkg::reg_type idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         gmss_pkg::REG_START_X: tool_pos[0] = val;
         gmss_pkg::REG_START_Y: tool_pos[1] = val;
         gmss_pkg::REG_START_Z: tool_pos[2] = val;
         gmss_pkg::REG_START_REL: rel_q = val[0];
         gmss_pkg::REG_XY_RAPID: xy_rapid = val[30:0];
         gmss_pkg::REG_XY_FEED: xy_feed = val[30:0];
         gmss_pkg::REG_Z_RAPID: z_rapid = val[30:0];
         gmss_pkg::REG_Z_FEED: z_feed = val[30:0];
         default: ;
      endcase
   endtask

   task automatic write_all_regs(input logic [31:0] sx, input logic [31:0] sy,
                                 input logic [31:0] sz, input logic rel,
                                 input logic [31:0] xyr, input logic [31:0] xyf,
                                 input logic [31:0] zr, input logic [31:0] zf);
      write_reg(gmss_pkg::REG_START_X, sx);
      write_reg(gmss_pkg::REG_START_Y, sy);
      write_reg(gmss_pkg::REG_START_Z, sz);
      write_reg(gmss_pkg::REG_START_REL, {31'b0, rel});
      write_reg(gmss_pkg::REG_XY_RAPID, xyr);
      write_reg(gmss_pkg::REG_XY_FEED, xyf);
      write_reg(gmss_pkg::REG_Z_RAPID, zr);
      write_reg(gmss_pkg::REG_Z_FEED, zf);
      csr_we <= 1'b0;
   endtask

   // Axis word: mostly near the current position, some far or extreme.
   function automatic logic [31:0] pick_axis_value(input logic [31:0] cur);
      logic [31:0] base;
      base = rel_q ? 32'd0 : cur;
      case ($urandom_range(9))
         0, 1, 2, 3: return base + $urandom_range(1 << 20) - (1 << 19);
         4, 5: return $urandom;
         6: return base;
         7: return 32'h8000_0000;
         8: return 32'h7FFF_FFFF;
         default: return base + $urandom_range(2) - 1;
      endcase
   endfunction

   task automatic test_directed();
      write_all_regs(32'd0, 32'd0, 32'd0, 1'b0, 32'h000A_0000, 32'h0002_8000,
                     32'h0005_0000, 32'h0001_0000);
      send_command(gmss_pkg::KIND_RAPID, 5'b00011, 32'h0064_0000, 32'h0032_0000, 0, 0);
      send_command(gmss_pkg::KIND_FEED, 5'b00010, 0, 32'hFFF0_0000, 0, 0);
      send_command(gmss_pkg::KIND_FEED, 5'b10000, 0, 0, 0, 0);
      send_command(gmss_pkg::KIND_RAPID, 5'b00111, 1, 2, 3, 0);
      send_command(gmss_pkg::KIND_RAPID, 5'b01011, 1, 2, 0, 4);
      // Zero move: same position as now.
      send_command(gmss_pkg::KIND_FEED, 5'b00001, tool_pos[0], 0, 0, 0);
      send_command(gmss_pkg::KIND_FEED, 5'b00100, 0, 0, 32'hFFFF_0000, 0);
      // A-only move keeps the velocities.
      send_command(gmss_pkg::KIND_RAPID, 5'b01000, 0, 0, 0, 32'h0123_4567);
      send_command(gmss_pkg::KIND_RAPID, 5'b00011, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
      send_command(gmss_pkg::KIND_FEED, 5'b00011, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send_command(gmss_pkg::KIND_FEED, 5'b00001, 32'h7FFF_FFFE, 0, 0, 0);
      send_command(gmss_pkg::KIND_DWELL, 5'b11111, '1, '1, '1, '1);
      send_command(gmss_pkg::KIND_DWELL, 5'b01111, 0, 0, 0, 0);
      send_command(gmss_pkg::KIND_REL, 5'b00000, 0, 0, 0, 0);
      // Relative move that wraps around the position range.
      send_command(gmss_pkg::KIND_RAPID, 5'b00011, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0);
      send_command(gmss_pkg::KIND_RAPID, 5'b00001, 32'hFFFF_FFFF, 0, 0, 0);
      send_command(gmss_pkg::KIND_ABS, 5'b00000, 0, 0, 0, 0);
      send_command(gmss_pkg::KIND_SPIN_CW, 5'b00000, 0, 0, 0, 0);
      send_command(gmss_pkg::KIND_SPIN_CCW, 5'b00000, 0, 0, 0, 0);
      send_command(gmss_pkg::KIND_SPIN_OFF, 5'b00000, 0, 0, 0, 0);
      send_command(gmss_pkg::KIND_END, 5'b00000, 0, 0, 0, 0);
      // Commands after program end are still processed.
      send_command(gmss_pkg::KIND_FEED, 5'b00010, 0, 32'h0000_0010, 0, 0);
      send_command(4'hF, 5'b11111, '1, '1, '1, '1);
      drain_results();
   endtask

   task automatic test_random(input int count);
      logic [3:0] kind;
      logic [4:0] has;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 65) kind = $urandom_range(1) ? gmss_pkg::KIND_RAPID : gmss_pkg::KIND_FEED;
         else if (r < 70) kind = gmss_pkg::KIND_DWELL;
         else if (r < 76) kind = gmss_pkg::KIND_ABS;
         else if (r < 82) kind = gmss_pkg::KIND_REL;
         else if (r < 84) kind = gmss_pkg::KIND_END;
         else if (r < 97)
            kind = 4'($urandom_range(gmss_pkg::KIND_SPIN_CW, gmss_pkg::KIND_SPIN_OFF));
         else kind = 4'($urandom_range(9, 15));
         has = 5'($urandom);
         // Favor legal axis sets so most moves get through.
         if (kind <= gmss_pkg::KIND_FEED && $urandom_range(3) != 0) begin
            case ($urandom_range(3))
               0: has[3:0] = 4'b0011;
               1: has[3:0] = {1'($urandom_range(1)), 1'b0, 2'($urandom_range(1, 3))};
               2: has[3:0] = 4'b0100;
               default: has[3:0] = 4'b1000;
            endcase
         end
         send_command(kind, has, pick_axis_value(tool_pos[0]), pick_axis_value(tool_pos[1]),
                      pick_axis_value(tool_pos[2]), pick_axis_value(tool_pos[3]));
         // Hold off once per phase until the block has caught up.
         if (n == count / 2) drain_results();
      end
      drain_results();
   endtask

   // Receiver side: stall at random.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // Compare each result beat with the oldest expected one.
   always @(posedge clock) begin
      motion_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $realtime, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("pos_x", want.px, got.px);
            check_field("pos_y", want.py, got.py);
            check_field("pos_z", want.pz, got.pz);
            check_field("pos_a", want.pa, got.pa);
            check_field("vel_x", want.vx, got.vx);
            check_field("vel_y", want.vy, got.vy);
            check_field("vel_z", 32'(want.vz), 32'(got.vz));
            check_field("spindle", 32'(want.spin), 32'(got.spin));
            check_field("moving", 32'(want.moving), 32'(got.moving));
            check_field("paused", 32'(want.paused), 32'(got.paused));
            check_field("program_end", 32'(want.prog_end), 32'(got.prog_end));
            check_field("error", 32'(want.err), 32'(got.err));
            check_field("fill", 32'(want.fill), 32'(got.fill));
         end
      end
   end

   initial begin
      #(12 * 2000000);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      for (int k = 0; k < 4; k++) tool_pos[k] = '0;
      vel_x_q = 0;
      vel_y_q = 0;
      vel_z_q = '0;
      spin_q = gmss_pkg::SPIN_STOP;
      rel_q = 0;
      end_q = 0;
      xy_rapid = '0;
      xy_feed = '0;
      z_rapid = '0;
      z_feed = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 31;
      recv_idle_pct = 57;
      test_directed();

      write_all_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      test_random(260);

      send_idle_pct = 57;
      recv_idle_pct = 31;
      write_all_regs(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'd0, 32'd0,
                     32'd0, 32'd0);
      test_random(260);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_all_regs($urandom, $urandom, $urandom, 1'($urandom), $urandom, $urandom,
                     $urandom, $urandom);
      test_random(260);

      repeat (200) @(negedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
